/* hw/rtl/uht_pkg.sv */
// Shared constants and types for the unordered handle table.
package uht_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int DATA_W   = 32;
	localparam int REQ_W    = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD           = 3'd0,
		REQ_REMOVE_HANDLE = 3'd1,
		REQ_REMOVE_INDEX  = 3'd2,
		REQ_FIND_HANDLE   = 3'd3,
		REQ_GET_BY_ID     = 3'd4,
		REQ_REMOVE_ID     = 3'd5,
		REQ_CLEAR         = 3'd6,
		REQ_READ_INDEX    = 3'd7
	} req_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_READ = 6'b000100,
		S_LAST = 6'b001000,
		S_MOVE = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

endpackage

/* hw/rtl/uht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module uht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/unordered_handle_table.sv */
// Unordered handle table: packed handle/ID store with swap-on-remove and linear search.
//
//   Channel   Handshake              Payload
//   request   req_valid/req_ready    req_type, unit_handle, unit_id, entry_index
//   response  rsp_valid/rsp_ready    hit, found_index, handle_out, live_count, full_reject
//
// Add, clear and rejected requests go straight to the done state, read index passes S_READ,
// and remove index passes S_LAST and S_MOVE. Searches read one entry per cycle through the
// single read port of the stores; a match that is removed then passes S_LAST and S_MOVE.
// After reset the table is empty and requests are taken at once.
// A new request is taken while an earlier response still waits; a stalled response
// holds the next result until the response register frees.
module unordered_handle_table
	import uht_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [DATA_W-1:0] unit_handle,
	input  logic [DATA_W-1:0] unit_id,
	input  logic [IDX_W-1:0]  entry_index,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              hit,
	output logic [IDX_W-1:0]  found_index,
	output logic [DATA_W-1:0] handle_out,
	output logic [CNT_W-1:0]  live_count,
	output logic              full_reject
);

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  k_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	req_t              req_q;
	logic [DATA_W-1:0] handle_q;
	logic [DATA_W-1:0] id_q;
	logic [IDX_W-1:0]  pos_q;
	logic              res_hit_q;
	logic [IDX_W-1:0]  res_fidx_q;
	logic [DATA_W-1:0] res_hout_q;
	logic              res_rej_q;
	logic              rsp_valid_q;
	logic              hit_q;
	logic [IDX_W-1:0]  found_index_q;
	logic [DATA_W-1:0] handle_out_q;
	logic [CNT_W-1:0]  live_count_q;
	logic              full_reject_q;

	logic              accept;
	logic              rsp_free;
	logic              by_id;
	logic              is_remove;
	logic              key_match;
	logic              idx_live;
	logic              has_room;
	logic [CNT_W-1:0]  last_cnt;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [DATA_W-1:0] wr_handle;
	logic [DATA_W-1:0] wr_id;
	logic [IDX_W-1:0]  raddr;
	logic [DATA_W-1:0] rd_handle;
	logic [DATA_W-1:0] rd_id;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign idx_live  = {1'b0, entry_index} < count_q;
	assign has_room  = count_q < CNT_W'(CAPACITY);
	assign last_cnt  = count_q - CNT_W'(1);
	assign by_id     = (req_q == REQ_GET_BY_ID) || (req_q == REQ_REMOVE_ID);
	assign is_remove = (req_q == REQ_REMOVE_HANDLE) || (req_q == REQ_REMOVE_ID);
	assign key_match = by_id ? (rd_id == id_q) : (rd_handle == handle_q);

	always_comb begin
		we        = 1'b0;
		waddr     = count_q[IDX_W-1:0];
		wr_handle = unit_handle;
		wr_id     = unit_id;
		raddr     = k_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				we    = accept && (req_type == REQ_ADD) && has_room;
				raddr = entry_index;
			end
			S_LAST: begin
				raddr = last_cnt[IDX_W-1:0];
			end
			S_MOVE: begin
				we        = 1'b1;
				waddr     = pos_q;
				wr_handle = rd_handle;
				wr_id     = rd_id;
			end
			default: begin
			end
		endcase
	end

	uht_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_handle_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_handle),
		.raddr (raddr),
		.rdata (rd_handle)
	);

	uht_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_id_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_id),
		.raddr (raddr),
		.rdata (rd_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						k_q      <= '0;
						valid_s1 <= 1'b0;
						unique case (req_type) inside
							REQ_ADD: begin
								if (has_room) begin
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= S_DONE;
							end
							REQ_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							REQ_READ_INDEX: begin
								state_q <= idx_live ? S_READ : S_DONE;
							end
							REQ_REMOVE_INDEX: begin
								state_q <= idx_live ? S_LAST : S_DONE;
							end
							REQ_REMOVE_HANDLE, REQ_FIND_HANDLE, REQ_GET_BY_ID, REQ_REMOVE_ID: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (valid_s1 && key_match) begin
						valid_s1 <= 1'b0;
						state_q  <= is_remove ? S_LAST : S_DONE;
					end else begin
						valid_s1 <= k_q < count_q;
						if (k_q < count_q) begin
							k_q <= k_q + CNT_W'(1);
						end else if (!valid_s1) begin
							state_q <= S_DONE;
						end
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_LAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					count_q <= last_cnt;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= k_q[IDX_W-1:0];
		if (accept) begin
			req_q      <= req_t'(req_type);
			handle_q   <= unit_handle;
			id_q       <= unit_id;
			pos_q      <= entry_index;
			res_fidx_q <= '0;
			res_hout_q <= '0;
			res_rej_q  <= (req_type == REQ_ADD) && !has_room;
			res_hit_q  <= ((req_type == REQ_ADD) && has_room) || (req_type == REQ_CLEAR) ||
				(((req_type == REQ_READ_INDEX) || (req_type == REQ_REMOVE_INDEX)) && idx_live);
		end
		if (state_q == S_SCAN && valid_s1 && key_match) begin
			res_hit_q <= 1'b1;
			pos_q     <= idx_s1;
			if (req_q == REQ_FIND_HANDLE) begin
				res_fidx_q <= idx_s1;
			end
			if (req_q == REQ_GET_BY_ID) begin
				res_hout_q <= rd_handle;
			end
		end
		if (state_q == S_READ) begin
			res_hout_q <= rd_handle;
		end
		if (state_q == S_DONE && rsp_free) begin
			hit_q         <= res_hit_q;
			found_index_q <= res_fidx_q;
			handle_out_q  <= res_hout_q;
			live_count_q  <= count_q;
			full_reject_q <= res_rej_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign found_index = found_index_q;
	assign handle_out  = handle_out_q;
	assign live_count  = live_count_q;
	assign full_reject = full_reject_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("Entry count exceeds capacity.");

	a_move_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> (count_q != '0))
		else $error("Entry move with an empty table.");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (k_q <= count_q))
		else $error("Search pointer ran past the live entries.");

	a_reject_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && full_reject) |-> !hit)
		else $error("Rejected add reported as a hit.");

	a_index_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (found_index != '0)) |-> hit)
		else $error("Nonzero match index without a hit.");
`endif

endmodule

/* tb/sv/unordered_handle_table_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the unordered handle table: directed, fill and random traffic.
module unordered_handle_table_test
	import uht_pkg::*;
();

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  found_index;
		logic [DATA_W-1:0] handle_out;
		logic [CNT_W-1:0]  live_count;
		logic              full_reject;
	} table_result_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	logic [REQ_W-1:0]  req_type;
	logic [DATA_W-1:0] unit_handle;
	logic [DATA_W-1:0] unit_id;
	logic [IDX_W-1:0]  entry_index;
	logic              rsp_valid;
	logic              rsp_ready;
	logic              hit;
	logic [IDX_W-1:0]  found_index;
	logic [DATA_W-1:0] handle_out;
	logic [CNT_W-1:0]  live_count;
	logic              full_reject;

	logic [DATA_W-1:0] tbl_handle [CAPACITY];
	logic [DATA_W-1:0] tbl_id [CAPACITY];
	logic [DATA_W-1:0] value_pool [16];
	int                tbl_count;
	table_result_t     pending_results [$];
	int                error_count;
	bit                stall_enable;

	unordered_handle_table u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.unit_handle (unit_handle),
		.unit_id     (unit_id),
		.entry_index (entry_index),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.hit         (hit),
		.found_index (found_index),
		.handle_out  (handle_out),
		.live_count  (live_count),
		.full_reject (full_reject)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// Applies one request to the shadow table and returns the response it must produce.
	function automatic table_result_t predict_request(req_t op, logic [DATA_W-1:0] h,
		logic [DATA_W-1:0] v, logic [IDX_W-1:0] idx);
		table_result_t r;
		int match_pos;
		int drop_pos;
		int k;
		r = '0;
		match_pos = -1;
		drop_pos = -1;
		for (k = 0; k < tbl_count; k++) begin
			if (match_pos < 0) begin
				if ((op == REQ_REMOVE_HANDLE || op == REQ_FIND_HANDLE) && tbl_handle[k] == h)
					match_pos = k;
				if ((op == REQ_GET_BY_ID || op == REQ_REMOVE_ID) && tbl_id[k] == v)
					match_pos = k;
			end
		end
		case (op)
			REQ_ADD: begin
				if (tbl_count < CAPACITY) begin
					tbl_handle[tbl_count] = h;
					tbl_id[tbl_count] = v;
					tbl_count++;
					r.hit = 1'b1;
				end else begin
					r.full_reject = 1'b1;
				end
			end
			REQ_REMOVE_HANDLE, REQ_REMOVE_ID: begin
				drop_pos = match_pos;
			end
			REQ_REMOVE_INDEX: begin
				if (idx < tbl_count)
					drop_pos = idx;
			end
			REQ_FIND_HANDLE: begin
				if (match_pos >= 0) begin
					r.hit = 1'b1;
					r.found_index = IDX_W'(match_pos);
				end
			end
			REQ_GET_BY_ID: begin
				if (match_pos >= 0) begin
					r.hit = 1'b1;
					r.handle_out = tbl_handle[match_pos];
				end
			end
			REQ_CLEAR: begin
				tbl_count = 0;
				r.hit = 1'b1;
			end
			REQ_READ_INDEX: begin
				if (idx < tbl_count) begin
					r.hit = 1'b1;
					r.handle_out = tbl_handle[idx];
				end
			end
			default: begin
			end
		endcase
		if (drop_pos >= 0) begin
			tbl_handle[drop_pos] = tbl_handle[tbl_count-1];
			tbl_id[drop_pos] = tbl_id[tbl_count-1];
			tbl_count--;
			r.hit = 1'b1;
		end
		r.live_count = CNT_W'(tbl_count);
		return r;
	endfunction

	task automatic send_request(req_t op, logic [DATA_W-1:0] h, logic [DATA_W-1:0] v,
		logic [IDX_W-1:0] idx);
		@(negedge clk);
		req_valid <= 1'b1;
		req_type <= op;
		unit_handle <= h;
		unit_id <= v;
		entry_index <= idx;
		do @(posedge clk); while (req_ready !== 1'b1);
		pending_results.push_back(predict_request(op, h, v, idx));
	endtask

	task automatic pause_requests(int cycles);
		@(negedge clk);
		req_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_all_results();
		pause_requests(1);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Mostly live keys so that searches hit, with a small pool for duplicates.
	function automatic logic [DATA_W-1:0] pick_key(bit by_id);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6 && tbl_count > 0)
			return by_id ? tbl_id[$urandom_range(0, tbl_count - 1)] :
				tbl_handle[$urandom_range(0, tbl_count - 1)];
		if (roll < 9)
			return value_pool[$urandom_range(0, 15)];
		return $urandom;
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		if (tbl_count > 0 && $urandom_range(0, 9) < 7)
			return IDX_W'($urandom_range(0, tbl_count - 1));
		return IDX_W'($urandom_range(0, CAPACITY - 1));
	endfunction

	task automatic random_request(int fill_goal);
		req_t op;
		int add_odds;
		add_odds = (tbl_count < fill_goal) ? 55 : 15;
		if ($urandom_range(0, 99) < add_odds) begin
			op = REQ_ADD;
		end else begin
			op = req_t'($urandom_range(1, 7));
			if (op == REQ_CLEAR && $urandom_range(0, 9) != 0)
				op = REQ_READ_INDEX;
		end
		send_request(op, pick_key(1'b0), pick_key(1'b1), pick_index());
	endtask

	task automatic test_empty_and_basic();
		send_request(REQ_READ_INDEX, 32'h0, 32'h0, 6'd0);
		send_request(REQ_FIND_HANDLE, 32'h0, 32'h0, 6'd0);
		send_request(REQ_GET_BY_ID, 32'h0, 32'hFFFF_FFFF, 6'd0);
		send_request(REQ_REMOVE_HANDLE, 32'hFFFF_FFFF, 32'h0, 6'd63);
		send_request(REQ_REMOVE_ID, 32'h0, 32'h0, 6'd0);
		send_request(REQ_REMOVE_INDEX, 32'h0, 32'h0, 6'd0);
		send_request(REQ_CLEAR, 32'h0, 32'h0, 6'd0);
		send_request(REQ_ADD, 32'h0, 32'h0, 6'd63);
		send_request(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
		send_request(REQ_ADD, 32'hFFFF_FFFF, 32'h0, 6'd0);
		send_request(REQ_ADD, 32'h1234_5678, 32'hFFFF_FFFF, 6'd0);
		send_request(REQ_FIND_HANDLE, 32'hFFFF_FFFF, 32'h0, 6'd0);
		send_request(REQ_GET_BY_ID, 32'h0, 32'h0, 6'd0);
		send_request(REQ_GET_BY_ID, 32'h0, 32'hFFFF_FFFF, 6'd0);
		send_request(REQ_READ_INDEX, 32'h0, 32'h0, 6'd3);
		send_request(REQ_READ_INDEX, 32'h0, 32'h0, 6'd63);
		send_request(REQ_REMOVE_INDEX, 32'h0, 32'h0, 6'd3);
		send_request(REQ_REMOVE_HANDLE, 32'h0, 32'h0, 6'd0);
		send_request(REQ_REMOVE_ID, 32'h0, 32'hFFFF_FFFF, 6'd0);
		send_request(REQ_FIND_HANDLE, 32'h5555_AAAA, 32'h0, 6'd0);
		send_request(REQ_REMOVE_INDEX, 32'h0, 32'h0, 6'd0);
		send_request(REQ_CLEAR, 32'h0, 32'h0, 6'd0);
	endtask

	task automatic test_fill_to_capacity();
		send_request(REQ_CLEAR, $urandom, $urandom, pick_index());
		repeat (CAPACITY)
			send_request(REQ_ADD, pick_key(1'b0), pick_key(1'b1), pick_index());
		send_request(REQ_ADD, $urandom, $urandom, pick_index());
		send_request(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
		send_request(REQ_READ_INDEX, 32'h0, 32'h0, 6'd63);
		send_request(REQ_FIND_HANDLE, tbl_handle[CAPACITY-1], 32'h0, 6'd0);
		send_request(REQ_GET_BY_ID, 32'h0, tbl_id[CAPACITY-1], 6'd0);
		send_request(REQ_REMOVE_INDEX, 32'h0, 32'h0, 6'd63);
		send_request(REQ_READ_INDEX, 32'h0, 32'h0, 6'd63);
		send_request(REQ_ADD, $urandom, $urandom, 6'd0);
		send_request(REQ_REMOVE_INDEX, 32'h0, 32'h0, 6'd0);
	endtask

	task automatic test_random_traffic(int count);
		int fill_goal;
		int n;
		fill_goal = CAPACITY / 2;
		for (n = 0; n < count; n++) begin
			if (n % 150 == 0) begin
				fill_goal = ($urandom_range(0, 3) == 0) ? CAPACITY : $urandom_range(0, CAPACITY);
				stall_enable = ($urandom_range(0, 3) != 0);
			end
			if (stall_enable && $urandom_range(0, 7) == 0)
				pause_requests($urandom_range(1, 18));
			random_request(fill_goal);
		end
	endtask

	task automatic test_steady_stream(int count);
		int fill_goal;
		int n;
		stall_enable = 1'b0;
		fill_goal = CAPACITY;
		for (n = 0; n < count; n++) begin
			if (n % 60 == 0)
				fill_goal = $urandom_range(0, CAPACITY);
			random_request(fill_goal);
		end
	endtask

	initial begin : drive_rsp_ready
		int hold;
		hold = 0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_ready <= 1'b0;
				hold--;
			end else begin
				rsp_ready <= 1'b1;
				if (stall_enable && $urandom_range(0, 9) == 0)
					hold = $urandom_range(1, 18);
			end
		end
	end

	always @(posedge clk) begin : check_response
		table_result_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected response", DATA_W'(live_count), 0);
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", DATA_W'(hit), DATA_W'(want.hit));
				if (found_index !== want.found_index)
					report_mismatch("found_index", DATA_W'(found_index),
						DATA_W'(want.found_index));
				if (handle_out !== want.handle_out)
					report_mismatch("handle_out", handle_out, want.handle_out);
				if (live_count !== want.live_count)
					report_mismatch("live_count", DATA_W'(live_count),
						DATA_W'(want.live_count));
				if (full_reject !== want.full_reject)
					report_mismatch("full_reject", DATA_W'(full_reject),
						DATA_W'(want.full_reject));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = REQ_ADD;
		unit_handle = '0;
		unit_id = '0;
		entry_index = '0;
		error_count = 0;
		tbl_count = 0;
		stall_enable = 1'b0;
		value_pool[0] = 32'h0;
		value_pool[1] = 32'hFFFF_FFFF;
		for (int k = 2; k < 16; k++)
			value_pool[k] = $urandom;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_and_basic();
		test_fill_to_capacity();
		wait_all_results();
		test_random_traffic(1000);
		wait_all_results();
		test_steady_stream(180);
		wait_all_results();
		repeat (100) @(posedge clk);

		if (pending_results.size() != 0)
			report_mismatch("missing responses", pending_results.size(), 0);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
